// ----- src/sthd_pkg.sv -----
// Shared types, constants and register codes for the scrollbar thumb engine.
// No dependencies.
package sthd_pkg;

  localparam int COORD_BITS = 16;
  localparam int ROW_BITS   = 32;
  localparam int PROD_BITS  = COORD_BITS + ROW_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = ROW_BITS;

  localparam logic [COORD_BITS-1:0] THUMB_MIN = COORD_BITS'(6);

  localparam int DIV_STEPS = 2;
  localparam int DIV_CYCLES = PROD_BITS / DIV_STEPS;
  localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

  localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_X      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_Y      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_ROWS   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VISIBLE_ROWS = 3'd5;

  localparam logic [2:0] OUTC_OUTSIDE = 3'd0;
  localparam logic [2:0] OUTC_NOSCROLL = 3'd1;
  localparam logic [2:0] OUTC_PAGE_BACK = 3'd2;
  localparam logic [2:0] OUTC_PAGE_FWD = 3'd3;
  localparam logic [2:0] OUTC_ON_THUMB = 3'd4;
  localparam logic [2:0] OUTC_DRAG = 3'd5;

  localparam logic OP_CLICK = 1'b0;
  localparam logic OP_DRAG  = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] grab_offset;
    logic [ROW_BITS-1:0]   first_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            outcome;
    logic [ROW_BITS-1:0]   new_first_row;
    logic [COORD_BITS-1:0] thumb_top;
    logic [COORD_BITS-1:0] thumb_height;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] track_x;
    logic [COORD_BITS-1:0] track_y;
    logic [COORD_BITS-1:0] track_width;
    logic [COORD_BITS-1:0] track_height;
    logic [ROW_BITS-1:0]   total_rows;
    logic [ROW_BITS-1:0]   visible_rows;
  } cfg_t;

  typedef struct packed {
    logic                  drag;
    logic                  in_track;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] grab_offset;
    logic [ROW_BITS-1:0]   first_row;
  } cls_item_t;

endpackage

// ----- src/sthd_front.sv -----
// Front end: accepts pointer events, does the track hit test and queues them.
// Depends on sthd_pkg.
module sthd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  sthd_pkg::cfg_t     cfg,
  input  logic               push,
  output logic               full,
  input  sthd_pkg::in_item_t in_data,
  output logic               q_empty,
  input  logic               q_pop,
  output sthd_pkg::cls_item_t q_item
);

  sthd_pkg::cls_item_t cls;
  sthd_pkg::cls_item_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       wr, rd;
  logic [sthd_pkg::COORD_BITS:0] x_end, y_end;

  always_comb begin
    x_end = {1'b0, cfg.track_x} + {1'b0, cfg.track_width};
    y_end = {1'b0, cfg.track_y} + {1'b0, cfg.track_height};
    cls.drag        = (in_data.operation == sthd_pkg::OP_DRAG);
    cls.in_track    = (in_data.cursor_x >= cfg.track_x) &&
                      ({1'b0, in_data.cursor_x} < x_end) &&
                      (in_data.cursor_y >= cfg.track_y) &&
                      ({1'b0, in_data.cursor_y} < y_end);
    cls.cursor_y    = in_data.cursor_y;
    cls.grab_offset = in_data.grab_offset;
    cls.first_row   = in_data.first_row;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign wr      = push && !full;
  assign rd      = q_pop && !q_empty;
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) ent_r[wr_ptr_r] <= cls;
  end

endmodule

// ----- src/sthd_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
// Depends on sthd_pkg.
module sthd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sthd_pkg::PROD_BITS-1:0]    num,
  input  logic [sthd_pkg::ROW_BITS-1:0]     den,
  output logic                              busy,
  output logic                              done,
  output logic [sthd_pkg::PROD_BITS-1:0]    quo
);

  logic [sthd_pkg::ROW_BITS-1:0]     rem_r, rem_nxt;
  logic [sthd_pkg::PROD_BITS-1:0]    quo_r, quo_nxt;
  logic [sthd_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                              busy_r, done_r;
  logic [sthd_pkg::ROW_BITS:0]       trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < sthd_pkg::DIV_STEPS; i++) begin
      trial = {rem_nxt, quo_nxt[sthd_pkg::PROD_BITS-1]};
      quo_nxt = {quo_nxt[sthd_pkg::PROD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[sthd_pkg::ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= sthd_pkg::DIV_CNT_BITS'(sthd_pkg::DIV_CYCLES - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - sthd_pkg::DIV_CNT_BITS'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- src/sthd_back.sv -----
// Back end: thumb geometry and new first row, using one shared divider,
// with an output register towards the result side.
// Depends on sthd_pkg and sthd_div.
module sthd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sthd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  output logic                q_pop,
  input  sthd_pkg::cls_item_t q_item,
  output logic                empty,
  input  logic                pop,
  output sthd_pkg::out_item_t out_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TH_MUL = 3'd1;
  localparam logic [2:0] ST_TH_DIV = 3'd2;
  localparam logic [2:0] ST_TY_MUL = 3'd3;
  localparam logic [2:0] ST_TY_DIV = 3'd4;
  localparam logic [2:0] ST_NF_MUL = 3'd5;
  localparam logic [2:0] ST_NF_DIV = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam int CB = sthd_pkg::COORD_BITS;
  localparam int RB = sthd_pkg::ROW_BITS;
  localparam int PB = sthd_pkg::PROD_BITS;

  logic [2:0]          st_r;
  logic                started_r;
  sthd_pkg::cls_item_t itm_r;
  logic [PB-1:0]       prod_r;
  logic [CB-1:0]       th_r, maxtop_r, ty_r;
  logic [RB-1:0]       nfq_r;
  logic                out_valid_r;
  sthd_pkg::out_item_t out_r;

  logic          div_start, div_busy, div_done;
  logic [PB-1:0] div_num, div_quo;
  logic [RB-1:0] div_den;

  logic          scrollable, degen;
  logic [RB-1:0] row_span, fc;
  logic [CB-1:0] th_new, want;
  logic [CB:0]   sub, want_w;
  logic          drag_ok;
  logic [CB-1:0] click;
  logic [CB:0]   thumb_end;
  logic [RB:0]   fwd_sum;
  sthd_pkg::out_item_t res;
  logic          out_wr;

  assign scrollable = cfg.total_rows > cfg.visible_rows;
  assign row_span   = scrollable ? cfg.total_rows - cfg.visible_rows : '0;
  assign degen      = (cfg.track_height == '0) || (cfg.total_rows == '0) ||
                      (cfg.visible_rows == '0) || !scrollable;
  assign fc         = (itm_r.first_row > row_span) ? row_span : itm_r.first_row;

  always_comb begin
    th_new = (div_quo < PB'(sthd_pkg::THUMB_MIN)) ? sthd_pkg::THUMB_MIN : div_quo[CB-1:0];
    if (th_new > cfg.track_height) th_new = cfg.track_height;
    if (degen) th_new = cfg.track_height;
  end

  always_comb begin
    sub    = {1'b0, cfg.track_y} + {1'b0, itm_r.grab_offset};
    want_w = ({1'b0, itm_r.cursor_y} > sub) ? {1'b0, itm_r.cursor_y} - sub : '0;
    want   = (want_w > {1'b0, maxtop_r}) ? maxtop_r : want_w[CB-1:0];
  end

  assign drag_ok = scrollable && (cfg.track_height != '0) && (maxtop_r != '0);

  always_comb begin
    click     = itm_r.cursor_y - cfg.track_y;
    thumb_end = {1'b0, ty_r} + {1'b0, th_r};
    fwd_sum   = {1'b0, itm_r.first_row} + {1'b0, cfg.visible_rows};
    res.thumb_top     = ty_r;
    res.thumb_height  = th_r;
    res.new_first_row = '0;
    if (itm_r.drag) begin
      res.outcome = sthd_pkg::OUTC_DRAG;
      if (drag_ok) res.new_first_row = nfq_r;
    end else if (!itm_r.in_track) begin
      res.outcome = sthd_pkg::OUTC_OUTSIDE;
    end else if (!scrollable) begin
      res.outcome = sthd_pkg::OUTC_NOSCROLL;
    end else if (click < ty_r) begin
      res.outcome = sthd_pkg::OUTC_PAGE_BACK;
      res.new_first_row = (itm_r.first_row > cfg.visible_rows) ?
                          itm_r.first_row - cfg.visible_rows : '0;
    end else if ({1'b0, click} >= thumb_end) begin
      res.outcome = sthd_pkg::OUTC_PAGE_FWD;
      res.new_first_row = (fwd_sum > {1'b0, row_span}) ? row_span : fwd_sum[RB-1:0];
    end else begin
      res.outcome = sthd_pkg::OUTC_ON_THUMB;
      res.new_first_row = itm_r.first_row;
    end
  end

  always_comb begin
    div_num   = prod_r;
    div_den   = cfg.total_rows;
    div_start = 1'b0;
    unique case (st_r)
      ST_TH_DIV: div_den = cfg.total_rows;
      ST_TY_DIV: div_den = row_span;
      ST_NF_DIV: div_den = RB'(maxtop_r);
      default:   div_den = cfg.total_rows;
    endcase
    if ((st_r == ST_TH_DIV || st_r == ST_TY_DIV || st_r == ST_NF_DIV) && !started_r) begin
      div_start = 1'b1;
    end
  end

  assign q_pop  = (st_r == ST_IDLE) && !q_empty;
  assign out_wr = (st_r == ST_OUT) && (!out_valid_r || pop);

  sthd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (div_start) started_r <= 1'b1;
      if (div_done) started_r <= 1'b0;
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE:   if (!q_empty) st_r <= ST_TH_MUL;
        ST_TH_MUL: st_r <= ST_TH_DIV;
        ST_TH_DIV: if (div_done) st_r <= ST_TY_MUL;
        ST_TY_MUL: st_r <= ST_TY_DIV;
        ST_TY_DIV: if (div_done) st_r <= itm_r.drag ? ST_NF_MUL : ST_OUT;
        ST_NF_MUL: st_r <= ST_NF_DIV;
        ST_NF_DIV: if (div_done) st_r <= ST_OUT;
        ST_OUT:    if (out_wr) st_r <= ST_IDLE;
        default:   st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) itm_r <= q_item;
    if (out_wr) out_r <= res;
    unique case (st_r)
      ST_TH_MUL: prod_r <= PB'(cfg.track_height) * PB'(cfg.visible_rows);
      ST_TH_DIV: if (div_done) begin
        th_r     <= th_new;
        maxtop_r <= cfg.track_height - th_new;
      end
      ST_TY_MUL: prod_r <= PB'(maxtop_r) * PB'(fc);
      ST_TY_DIV: if (div_done) ty_r <= scrollable ? div_quo[CB-1:0] : '0;
      ST_NF_MUL: prod_r <= PB'(row_span) * PB'(want);
      ST_NF_DIV: if (div_done) nfq_r <= div_quo[RB-1:0];
      default: ;
    endcase
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE) else $error("queue read outside idle");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && out_valid_r && !pop) |=> st_r == ST_OUT)
    else $error("result written over a waiting one");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> started_r) else $error("divider result with no request");
`endif

endmodule

// ----- src/scrollbar_thumb_hit_and_drag.sv -----
// Top level of the scrollbar thumb engine: configuration registers, front end
// and back end. Depends on sthd_pkg, sthd_front, sthd_back.
//
// One result per pointer event. Each division runs on the shared divider, two
// quotient bits at a time; a click takes two divisions and a drag three. The
// back end takes the next event only once a result moves to the output
// register, so it works on one event at a time. Two events queue in front of
// the back end and one result waits in the output register.
module scrollbar_thumb_hit_and_drag (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  sthd_pkg::in_item_t                    in_data,
  output logic                                  empty,
  input  logic                                  pop,
  output sthd_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [sthd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [sthd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  sthd_pkg::cfg_t      cfg_r;
  logic                q_empty, q_pop;
  sthd_pkg::cls_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sthd_pkg::CFG_TRACK_X:      cfg_r.track_x <= cfg_data[sthd_pkg::COORD_BITS-1:0];
        sthd_pkg::CFG_TRACK_Y:      cfg_r.track_y <= cfg_data[sthd_pkg::COORD_BITS-1:0];
        sthd_pkg::CFG_TRACK_WIDTH:  cfg_r.track_width <= cfg_data[sthd_pkg::COORD_BITS-1:0];
        sthd_pkg::CFG_TRACK_HEIGHT: cfg_r.track_height <= cfg_data[sthd_pkg::COORD_BITS-1:0];
        sthd_pkg::CFG_TOTAL_ROWS:   cfg_r.total_rows <= cfg_data[sthd_pkg::ROW_BITS-1:0];
        sthd_pkg::CFG_VISIBLE_ROWS: cfg_r.visible_rows <= cfg_data[sthd_pkg::ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  sthd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  sthd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
// Testbench for scrollbar_thumb_hit_and_drag: drives clicks and drags through
// several track/row settings and checks each result against a local predictor.
// Depends on sthd_pkg and the block under test.
`timescale 1ns / 1ps

class thumb_scoreboard;
  sthd_pkg::out_item_t expected_q[$];
  int mismatches;
  int checked;

  function void note_event(sthd_pkg::out_item_t exp_item);
    expected_q.push_back(exp_item);
  endfunction

  function void check_result(sthd_pkg::out_item_t got);
    sthd_pkg::out_item_t exp_item;
    bit bad;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_item = expected_q.pop_front();
    checked++;
    bad = (got.outcome !== exp_item.outcome) ||
          (got.new_first_row !== exp_item.new_first_row) ||
          (got.thumb_top !== exp_item.thumb_top) ||
          (got.thumb_height !== exp_item.thumb_height);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp oc=%0d nf=%0d top=%0d h=%0d got oc=%0d nf=%0d top=%0d h=%0d",
                 exp_item.outcome, exp_item.new_first_row, exp_item.thumb_top,
                 exp_item.thumb_height, got.outcome, got.new_first_row,
                 got.thumb_top, got.thumb_height);
    end
  endfunction
endclass

module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  sthd_pkg::in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  sthd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [sthd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [sthd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  sthd_pkg::cfg_t track_cfg;
  thumb_scoreboard sb;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  scrollbar_thumb_hit_and_drag u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sthd_pkg::out_item_t predict_geometry(sthd_pkg::in_item_t ev);
    sthd_pkg::out_item_t r;
    longint unsigned h, tot, vis, th, ty, row_span, max_top, fc, nf, click;
    longint unsigned sub, want;
    h = track_cfg.track_height;
    tot = track_cfg.total_rows;
    vis = track_cfg.visible_rows;
    if (h == 0 || tot == 0 || vis == 0 || vis >= tot) th = h;
    else begin
      th = (h * vis) / tot;
      if (th < 6) th = 6;
      if (th > h) th = h;
    end
    row_span = (tot > vis) ? tot - vis : 0;
    max_top = (h > th) ? h - th : 0;
    ty = 0;
    if (tot > vis) begin
      fc = (ev.first_row > row_span) ? row_span : ev.first_row;
      ty = (max_top * fc) / row_span;
      if (ty > max_top) ty = max_top;
    end
    nf = 0;
    if (ev.operation == sthd_pkg::OP_CLICK) begin
      if (ev.cursor_x < track_cfg.track_x ||
          ev.cursor_x >= longint'(track_cfg.track_x) + track_cfg.track_width ||
          ev.cursor_y < track_cfg.track_y ||
          ev.cursor_y >= longint'(track_cfg.track_y) + h) begin
        r.outcome = sthd_pkg::OUTC_OUTSIDE;
      end else if (tot <= vis) begin
        r.outcome = sthd_pkg::OUTC_NOSCROLL;
      end else begin
        click = ev.cursor_y - track_cfg.track_y;
        if (click < ty) begin
          r.outcome = sthd_pkg::OUTC_PAGE_BACK;
          nf = (ev.first_row > vis) ? ev.first_row - vis : 0;
        end else if (click >= ty + th) begin
          r.outcome = sthd_pkg::OUTC_PAGE_FWD;
          nf = ev.first_row + vis;
          if (nf > row_span) nf = row_span;
        end else begin
          r.outcome = sthd_pkg::OUTC_ON_THUMB;
          nf = ev.first_row;
        end
      end
    end else begin
      r.outcome = sthd_pkg::OUTC_DRAG;
      if (tot > vis && h != 0 && max_top != 0) begin
        sub = longint'(track_cfg.track_y) + ev.grab_offset;
        want = (ev.cursor_y > sub) ? ev.cursor_y - sub : 0;
        if (want > max_top) want = max_top;
        nf = (row_span * want) / max_top;
      end
    end
    r.new_first_row = nf[31:0];
    r.thumb_top = ty[15:0];
    r.thumb_height = th[15:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [sthd_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      sthd_pkg::CFG_TRACK_X: track_cfg.track_x = val[15:0];
      sthd_pkg::CFG_TRACK_Y: track_cfg.track_y = val[15:0];
      sthd_pkg::CFG_TRACK_WIDTH: track_cfg.track_width = val[15:0];
      sthd_pkg::CFG_TRACK_HEIGHT: track_cfg.track_height = val[15:0];
      sthd_pkg::CFG_TOTAL_ROWS: track_cfg.total_rows = val;
      sthd_pkg::CFG_VISIBLE_ROWS: track_cfg.visible_rows = val;
      default: ;
    endcase
  endtask

  task automatic set_track(int x, int y, int w, int h, int unsigned tot, int unsigned vis);
    write_reg(sthd_pkg::CFG_TRACK_X, x);
    write_reg(sthd_pkg::CFG_TRACK_Y, y);
    write_reg(sthd_pkg::CFG_TRACK_WIDTH, w);
    write_reg(sthd_pkg::CFG_TRACK_HEIGHT, h);
    write_reg(sthd_pkg::CFG_TOTAL_ROWS, tot);
    write_reg(sthd_pkg::CFG_VISIBLE_ROWS, vis);
    cfg_we <= 1'b0;
  endtask

  // push is left high after a transfer so back-to-back events need no gap
  task automatic send_event(sthd_pkg::in_item_t ev, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (full);
    sb.note_event(predict_geometry(ev));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic sthd_pkg::in_item_t random_event();
    sthd_pkg::in_item_t ev;
    int unsigned span;
    ev.operation = $urandom_range(0, 1);
    ev.grab_offset = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
    span = track_cfg.track_height + 20;
    if ($urandom_range(0, 9) < 8) begin
      ev.cursor_x = track_cfg.track_x + $urandom_range(0, track_cfg.track_width);
      ev.cursor_y = track_cfg.track_y + $urandom_range(0, span > 65535 ? 65535 : span) - 10;
    end else begin
      ev.cursor_x = $urandom;
      ev.cursor_y = $urandom;
    end
    case ($urandom_range(0, 3))
      0: ev.first_row = $urandom;
      1: ev.first_row = $urandom_range(0, 3);
      default: ev.first_row = (track_cfg.total_rows == 0) ? $urandom_range(0, 100) :
                   $urandom_range(0, track_cfg.total_rows);
    endcase
    return ev;
  endfunction

  task automatic random_phase(int count, bit stall_phase);
    int stretch;
    stretch = 0;
    for (int i = 0; i < count; i++) begin
      if (stall_phase && i == 2) hold_off = 1'b1;
      if (stretch == 0 && $urandom_range(0, 9) == 0) stretch = $urandom_range(5, 15);
      send_event(random_event(), stretch != 0);
      if (stretch != 0) stretch--;
      if (i == count / 2 && !stall_phase) begin
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    sthd_pkg::in_item_t ev;
    sb = new();
    track_cfg = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: zero-sized track
    ev = '0; send_event(ev, 0);
    ev.operation = sthd_pkg::OP_DRAG; send_event(ev, 0);
    drain();

    set_track(10, 20, 8, 100, 1000, 100);
    ev = '{sthd_pkg::OP_CLICK, 12, 25, 0, 500}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 115, 0, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 20, 0, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 60, 0, 450}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 9, 60, 0, 450}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 18, 60, 0, 450}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 120, 0, 450}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 30, 0, 32'hFFFFFFFF}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 12, 119, 0, 850}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 16'hFFFF, 60, 5, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 0, 0, 0, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 0, 16'hFFFF, 0, 3}; send_event(ev, 0);
    drain();

    set_track(0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1);
    ev = '{sthd_pkg::OP_CLICK, 16'hFFFE, 16'hFFFE, 0, 32'hFFFFFFFF}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 0, 16'hFFFF, 0, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 0, 16'hFFFF, 0, 0}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_CLICK, 100, 3, 0, 32'hFFFFFFFF}; send_event(ev, 0);
    drain();

    set_track(16'hFFF0, 16'hFFF0, 16'hFFFF, 4, 50, 50);
    ev = '{sthd_pkg::OP_CLICK, 16'hFFF5, 16'hFFF1, 0, 7}; send_event(ev, 0);
    ev = '{sthd_pkg::OP_DRAG, 16'hFFF5, 16'hFFF3, 0, 7}; send_event(ev, 0);
    drain();

    set_track(5, 5, 20, 40, 100, 90);
    random_phase(110, 0);
    drain();
    set_track(0, 100, 12, 300, 2000, 0);
    random_phase(110, 0);
    drain();
    set_track(200, 16'hFF00, 30, 16'h00F0, 32'h0FFFFFFF, 32'h00001000);
    random_phase(110, 1);
    drain();
    set_track($urandom_range(0, 500), $urandom_range(0, 500), $urandom_range(1, 60),
              $urandom_range(1, 3), $urandom_range(2, 100), $urandom_range(1, 3));
    random_phase(110, 0);
    drain();
    set_track(0, 0, 16'hFFFF, 16'hFFFF, $urandom, $urandom_range(0, 1000));
    random_phase(110, 0);
    drain();
    stim_done = 1'b1;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
        pop <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_data);
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sb != null);
    forever begin
      @(posedge clk);
      if (stim_done) begin
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
      end else if (idle_cycles > 5000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end
endmodule
